### rtl/hmmul4_pkg.sv
// Shared types and constants for the 4x4 homogeneous matrix multiplier.
package hmmul4_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = 2;
    localparam int ADDR_BITS  = 2 * IDX_BITS;
    localparam int MAT_DEPTH  = 1 << ADDR_BITS;

    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [ADDR_BITS-1:0] t_addr;

    localparam t_idx IDX_MAX = t_idx'((1 << IDX_BITS) - 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MULT  = 1'b1;
    localparam logic SEL_FIRST = 1'b0;
    localparam logic SEL_NEXT  = 1'b1;

    typedef struct packed {
        logic vld;
        logic first;
        logic last_k;
        t_idx row;
        t_idx col;
        logic last;
    } t_mac_ctl;

endpackage

### rtl/hmmul4_if.sv
// Handshake interfaces for the input items and the product items.
interface hmmul4_in_if;
    import hmmul4_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         op;
    logic                         matrix_sel;
    t_idx                         row;
    t_idx                         col;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, op, matrix_sel, row, col, value, input ready);
    modport sink (input valid, op, matrix_sel, row, col, value, output ready);
endinterface

interface hmmul4_out_if;
    import hmmul4_pkg::*;

    logic                         valid;
    logic                         ready;
    t_idx                         out_row;
    t_idx                         out_col;
    logic signed [VALUE_BITS-1:0] product_value;
    logic                         last;

    modport source (output valid, out_row, out_col, product_value, last, input ready);
    modport sink (input valid, out_row, out_col, product_value, last, output ready);
endinterface

### rtl/hmmul4_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hmmul4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hmmul4_mac.sv
// Pipelined multiply-accumulate with final shift and saturation.
module hmmul4_mac #(
    parameter int FRAC_BITS = hmmul4_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = hmmul4_pkg::WORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  hmmul4_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [WORD_BITS-1:0]          i_a,
    input  logic signed [WORD_BITS-1:0]          i_b,
    output hmmul4_pkg::t_mac_ctl                 o_ctl,
    output logic signed [hmmul4_pkg::VALUE_BITS-1:0] o_value
);
    import hmmul4_pkg::*;

    localparam int H  = WORD_BITS / 2;
    localparam int L  = WORD_BITS - H;
    localparam int PW = 2 * WORD_BITS;
    localparam int AW = PW + 2;
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

    logic [H-1:0]          a_lo, b_lo;
    logic signed [L-1:0]   a_hi, b_hi;
    logic [2*H-1:0]        n_pll, r_pll;
    logic signed [H+L:0]   n_plh, r_plh, n_phl, r_phl;
    logic signed [2*L-1:0] n_phh, r_phh;
    logic signed [PW-1:0]  n_prod, r_prod;
    logic signed [AW-1:0]  n_acc, r_acc, shifted;
    logic signed [WORD_BITS-1:0] sat;
    t_mac_ctl              r_s2_ctl, r_s3_ctl, r_acc_ctl, n_acc_ctl;

    assign a_lo = i_a[H-1:0];
    assign b_lo = i_b[H-1:0];
    assign a_hi = i_a[WORD_BITS-1:H];
    assign b_hi = i_b[WORD_BITS-1:H];

    always_comb begin
        n_pll = (2*H)'(a_lo) * (2*H)'(b_lo);
        n_plh = (H+L+1)'($signed({1'b0, a_lo})) * (H+L+1)'(b_hi);
        n_phl = (H+L+1)'(a_hi) * (H+L+1)'($signed({1'b0, b_lo}));
        n_phh = (2*L)'(a_hi) * (2*L)'(b_hi);
    end

    always_comb begin
        n_prod = (PW'(r_phh) <<< (2 * H))
               + ((PW'(r_plh) + PW'(r_phl)) <<< H)
               + PW'(r_pll);
    end

    always_comb begin
        n_acc = r_acc;
        if (r_s3_ctl.vld) begin
            n_acc = r_s3_ctl.first ? AW'(r_prod) : r_acc + AW'(r_prod);
        end
        n_acc_ctl = r_s3_ctl;
        n_acc_ctl.vld = r_s3_ctl.vld && r_s3_ctl.last_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl  <= '0;
            r_s3_ctl  <= '0;
            r_acc_ctl <= '0;
        end else if (i_en) begin
            r_s2_ctl  <= i_ctl;
            r_s3_ctl  <= r_s2_ctl;
            r_acc_ctl <= n_acc_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pll  <= n_pll;
            r_plh  <= n_plh;
            r_phl  <= n_phl;
            r_phh  <= n_phh;
            r_prod <= n_prod;
            r_acc  <= n_acc;
        end
    end

    always_comb begin
        shifted = r_acc >>> FRAC_BITS;
        if (shifted > SAT_HI) begin
            sat = SAT_HI[WORD_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            sat = SAT_LO[WORD_BITS-1:0];
        end else begin
            sat = shifted[WORD_BITS-1:0];
        end
    end

    assign o_ctl   = r_acc_ctl;
    assign o_value = VALUE_BITS'(sat);

endmodule

### rtl/homogeneous_matrix_multiply_4x4.sv
// Top level of the 4x4 homogeneous matrix multiplier in signed fixed point.
//
// Input channel i_in: each item writes one element (row, col, value) of the
// first (left) or next (right) matrix. An item with op set writes its element
// and then starts the product first x next.
// Output channel o_out: sixteen product items per multiply, row-major, the
// sixteenth marked by last. Each is the four-term sum shifted right by
// FRAC_BITS and saturated to WORD_BITS.
// Sequencing: a multiply reads both matrix memories once per term, one term per
// cycle while the output register is not stalled, for all 64 terms, and yields
// one product item per four terms through the memory read registers, the MAC
// registers and the output register. i_in.ready is low while the sequencer runs.
// Reset: both matrices read as identity; per-entry valid bits stand in for
// the reset contents until an element is written. No clearing pass.
// Stall: while a product item waits in the output register, the whole
// multiply pipeline and the memory read registers hold.
module homogeneous_matrix_multiply_4x4 #(
    parameter int FRAC_BITS = hmmul4_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = hmmul4_pkg::WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hmmul4_in_if.sink    i_in,
    hmmul4_out_if.source o_out
);
    import hmmul4_pkg::*;

    localparam logic [63:0] ONE_WIDE = 64'd1 << FRAC_BITS;
    localparam logic [WORD_BITS-1:0] ONE = ONE_WIDE[WORD_BITS-1:0];

    logic                  accept, en, re;
    logic                  we_a, we_b;
    t_addr                 waddr, raddr_a, raddr_b;
    logic [WORD_BITS-1:0]  wdata, rdata_a, rdata_b;
    logic signed [WORD_BITS-1:0] opa, opb;
    logic [MAT_DEPTH-1:0]  r_vld_a, r_vld_b;
    logic                  r_run;
    t_idx                  r_row, r_col, r_k;
    t_mac_ctl              r_s1_ctl, n_s1_ctl, mac_ctl;
    logic                  r_s1_va, r_s1_vb, r_s1_da, r_s1_db;
    logic signed [VALUE_BITS-1:0] mac_value;
    logic                  r_out_valid;
    t_idx                  r_out_row, r_out_col;
    logic                  r_out_last;
    logic signed [VALUE_BITS-1:0] r_out_value;

    assign i_in.ready = !r_run;
    assign accept     = i_in.valid && i_in.ready;
    assign en         = !r_out_valid || o_out.ready;
    assign re         = en && r_run;

    assign waddr = {i_in.row, i_in.col};
    assign wdata = WORD_BITS'(i_in.value);
    assign we_a  = accept && (i_in.matrix_sel == SEL_FIRST);
    assign we_b  = accept && (i_in.matrix_sel == SEL_NEXT);

    assign raddr_a = {r_row, r_k};
    assign raddr_b = {r_k, r_col};

    hmmul4_ram #(.WIDTH(WORD_BITS), .DEPTH(MAT_DEPTH)) u_ram_first (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    hmmul4_ram #(.WIDTH(WORD_BITS), .DEPTH(MAT_DEPTH)) u_ram_next (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
        end else begin
            if (we_a) begin
                r_vld_a[waddr] <= 1'b1;
            end
            if (we_b) begin
                r_vld_b[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
        end else if (accept && (i_in.op == OP_MULT)) begin
            r_run <= 1'b1;
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
        end else if (re) begin
            r_k <= r_k + t_idx'(1);
            if (r_k == IDX_MAX) begin
                r_col <= r_col + t_idx'(1);
                if (r_col == IDX_MAX) begin
                    r_row <= r_row + t_idx'(1);
                    if (r_row == IDX_MAX) begin
                        r_run <= 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        n_s1_ctl.vld    = r_run;
        n_s1_ctl.first  = (r_k == '0);
        n_s1_ctl.last_k = (r_k == IDX_MAX);
        n_s1_ctl.row    = r_row;
        n_s1_ctl.col    = r_col;
        n_s1_ctl.last   = (r_row == IDX_MAX) && (r_col == IDX_MAX) && (r_k == IDX_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (en) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_va <= r_vld_a[raddr_a];
            r_s1_vb <= r_vld_b[raddr_b];
            r_s1_da <= (r_row == r_k);
            r_s1_db <= (r_k == r_col);
        end
    end

    assign opa = r_s1_va ? rdata_a : (r_s1_da ? ONE : '0);
    assign opb = r_s1_vb ? rdata_b : (r_s1_db ? ONE : '0);

    hmmul4_mac #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_s1_ctl),
        .i_a     (opa),
        .i_b     (opb),
        .o_ctl   (mac_ctl),
        .o_value (mac_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= mac_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_row   <= mac_ctl.row;
            r_out_col   <= mac_ctl.col;
            r_out_last  <= mac_ctl.last;
            r_out_value <= mac_value;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.product_value = r_out_value;
    assign o_out.last          = r_out_last;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.product_value)
            && $stable(o_out.out_row) && $stable(o_out.out_col) && $stable(o_out.last)))
        else $error("Product item changed while it waited for the receiver.");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == ((o_out.out_row == IDX_MAX) && (o_out.out_col == IDX_MAX))))
        else $error("Last flag does not match the final product position.");

    a_mult_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.op == OP_MULT)) |=> (r_run && (r_row == '0) && (r_col == '0) && (r_k == '0)))
        else $error("Multiply item did not start the sequencer at the first element.");
`endif

endmodule
